// ----- rtl/olig_pkg.sv -----
// Shared types, codes and defaults for the ordered list block.
`default_nettype none
package olig_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int MODE_W   = 2;
	localparam int POS_W    = 7;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int FIDX_W   = 6;
	localparam int LEN_W    = 7;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_GET    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOCATE = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_GET    = 2'd2,
		ACT_LOCATE = 2'd3
	} act_t;

	typedef struct packed {
		logic    valid;
		act_t    act;
		status_t status;
		logic    hit;
	} tok_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/olig_cell.sv -----
// One list cell: holds one entry and works on the request passing through it.
`default_nettype none
module olig_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int IDX_W      = 6,
	parameter int CELL_IDX   = 0
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire olig_pkg::tok_ctl_t     in_ctl,
	input  wire logic [CNT_W-1:0]       in_tgt,
	input  wire logic [CNT_W-1:0]       in_lim,
	input  wire logic [CNT_W-1:0]       in_len,
	input  wire logic [IDX_W-1:0]       in_idx,
	input  wire logic [DATA_WIDTH-1:0]  in_word,
	input  wire logic [DATA_WIDTH-1:0]  in_rd,
	output olig_pkg::tok_ctl_t          out_ctl,
	output logic      [CNT_W-1:0]       out_tgt,
	output logic      [CNT_W-1:0]       out_lim,
	output logic      [CNT_W-1:0]       out_len,
	output logic      [IDX_W-1:0]       out_idx,
	output logic      [DATA_WIDTH-1:0]  out_word,
	output logic      [DATA_WIDTH-1:0]  out_rd
);
	import olig_pkg::*;

	localparam logic [CNT_W-1:0] K = CNT_W'(CELL_IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	tok_ctl_t              ctl_q;
	logic [CNT_W-1:0]      tgt_q;
	logic [CNT_W-1:0]      lim_q;
	logic [CNT_W-1:0]      len_q;
	logic [IDX_W-1:0]      idx_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] rd_q;

	tok_ctl_t              nxt_ctl;
	logic [IDX_W-1:0]      nxt_idx;
	logic [DATA_WIDTH-1:0] nxt_word;
	logic [DATA_WIDTH-1:0] nxt_rd;
	logic                  wr;

	always_comb begin
		nxt_ctl  = in_ctl;
		nxt_idx  = in_idx;
		nxt_word = in_word;
		nxt_rd   = in_rd;
		wr       = 1'b0;
		if (in_ctl.valid) begin
			case (in_ctl.act)
				ACT_INSERT: begin
					if (K >= in_tgt && K <= in_lim) begin
						wr       = 1'b1;
						nxt_word = entry_q;
					end
				end
				ACT_GET: begin
					if (K == in_tgt) begin
						nxt_rd = entry_q;
					end
				end
				ACT_LOCATE: begin
					if (!in_ctl.hit && K < in_lim && entry_q == in_word) begin
						nxt_ctl.hit    = 1'b1;
						nxt_ctl.status = ST_OK;
						nxt_idx        = IDX_W'(CELL_IDX);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en && wr) begin
			entry_q <= in_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= nxt_ctl;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tgt_q  <= in_tgt;
			lim_q  <= in_lim;
			len_q  <= in_len;
			idx_q  <= nxt_idx;
			word_q <= nxt_word;
			rd_q   <= nxt_rd;
		end
	end

	assign out_ctl  = ctl_q;
	assign out_tgt  = tgt_q;
	assign out_lim  = lim_q;
	assign out_len  = len_q;
	assign out_idx  = idx_q;
	assign out_word = word_q;
	assign out_rd   = rd_q;

endmodule
`default_nettype wire

// ----- rtl/ordered_list_insert_get_locate.sv -----
// Top level of the ordered list: request decode, length counter and the cell chain.
`default_nettype none
// Bounded ordered list of signed words held in a chain of CAPACITY cells, one entry
// per cell. Each request (insert at a 1-based position, get by 1-based position,
// locate the first entry equal to a value) is decoded on entry, then travels down
// the chain one cell per cycle while the chain advances; every cell shifts, reads or
// compares its own entry as the request passes, and the last cell's register is the
// result register. One request enters per cycle while in_ready is high; each one
// passes every cell's register in turn, and results leave in request order. When a
// result is not taken the whole chain holds and in_ready drops. list_length reports
// the length after the request; status (but a locate hit, set by the matching cell),
// length and the full/position checks are settled on entry by the length counter.
module ordered_list_insert_get_locate #(
	parameter int CAPACITY   = olig_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = olig_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [olig_pkg::MODE_W-1:0]      mode,
	input  wire logic [olig_pkg::POS_W-1:0]       position,
	input  wire logic signed [olig_pkg::VALUE_W-1:0] item_value,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic      [olig_pkg::STATUS_W-1:0]    status,
	output logic signed [olig_pkg::VALUE_W-1:0]   read_value,
	output logic      [olig_pkg::FIDX_W-1:0]      found_index,
	output logic      [olig_pkg::LEN_W-1:0]       list_length
);
	import olig_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	logic [CW-1:0] count_q;
	logic          advance;

	tok_ctl_t              ctl_c  [CAPACITY+1];
	logic [CW-1:0]         tgt_c  [CAPACITY+1];
	logic [CW-1:0]         lim_c  [CAPACITY+1];
	logic [CW-1:0]         len_c  [CAPACITY+1];
	logic [IW-1:0]         idx_c  [CAPACITY+1];
	logic [DATA_WIDTH-1:0] word_c [CAPACITY+1];
	logic [DATA_WIDTH-1:0] rd_c   [CAPACITY+1];

	logic [PW-1:0] pos_w;
	logic [PW-1:0] cnt_w;
	logic [63:0]   item_ext;
	logic [63:0]   rd_ext;
	logic [63:0]   idx_ext;
	logic [63:0]   len_ext;

	assign out_valid = ctl_c[CAPACITY].valid;
	assign advance   = !out_valid || out_ready;
	assign in_ready  = advance;

	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);
	assign item_ext = 64'(item_value);

	always_comb begin
		ctl_c[0].valid  = in_valid;
		ctl_c[0].act    = ACT_NONE;
		ctl_c[0].status = ST_BAD_POS;
		ctl_c[0].hit    = 1'b0;
		tgt_c[0]        = CW'(pos_w - PW'(1));
		lim_c[0]        = count_q;
		len_c[0]        = count_q;
		idx_c[0]        = '0;
		word_c[0]       = item_ext[DATA_WIDTH-1:0];
		rd_c[0]         = '0;
		case (mode)
			MODE_INSERT: begin
				if (pos_w == '0 || pos_w > cnt_w + PW'(1)) begin
					ctl_c[0].status = ST_BAD_POS;
				end else if (count_q == CW'(CAPACITY)) begin
					ctl_c[0].status = ST_FULL;
				end else begin
					ctl_c[0].act    = ACT_INSERT;
					ctl_c[0].status = ST_OK;
					len_c[0]        = count_q + CW'(1);
				end
			end
			MODE_GET: begin
				if (pos_w != '0 && pos_w <= cnt_w) begin
					ctl_c[0].act    = ACT_GET;
					ctl_c[0].status = ST_OK;
				end
			end
			MODE_LOCATE: begin
				ctl_c[0].act    = ACT_LOCATE;
				ctl_c[0].status = ST_NOT_FOUND;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_valid && in_ready && ctl_c[0].act == ACT_INSERT) begin
			count_q <= count_q + CW'(1);
		end
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		olig_cell #(
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CW),
			.IDX_W      (IW),
			.CELL_IDX   (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.in_ctl   (ctl_c[k]),
			.in_tgt   (tgt_c[k]),
			.in_lim   (lim_c[k]),
			.in_len   (len_c[k]),
			.in_idx   (idx_c[k]),
			.in_word  (word_c[k]),
			.in_rd    (rd_c[k]),
			.out_ctl  (ctl_c[k+1]),
			.out_tgt  (tgt_c[k+1]),
			.out_lim  (lim_c[k+1]),
			.out_len  (len_c[k+1]),
			.out_idx  (idx_c[k+1]),
			.out_word (word_c[k+1]),
			.out_rd   (rd_c[k+1])
		);
	end

	assign rd_ext  = 64'(signed'(rd_c[CAPACITY]));
	assign idx_ext = 64'(idx_c[CAPACITY]);
	assign len_ext = 64'(len_c[CAPACITY]);

	assign status      = ctl_c[CAPACITY].status;
	assign read_value  = rd_ext[VALUE_W-1:0];
	assign found_index = idx_ext[FIDX_W-1:0];
	assign list_length = len_ext[LEN_W-1:0];

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length above capacity");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == CW'(CAPACITY)) |=> $stable(count_q))
		else $error("full list changed length");

	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == ST_NOT_FOUND) |-> (found_index == '0 && read_value == '0))
		else $error("not-found result carries data");

	a_stall_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready && in_valid) |=> $stable(count_q))
		else $error("request taken while result stalled");
`endif

endmodule
`default_nettype wire
